// ----- hw/rtl/ppa_pkg.sv -----
// ----------------------------------------------------------------------------
// ppa_pkg: shared types and constants of the point partition assigner
// Sizes of the partition table, coordinate widths, item kinds and the word
// and accumulator records that move along the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package ppa_pkg;

    localparam int MAX_PARTITIONS = 16;
    localparam int IDX_W          = $clog2(MAX_PARTITIONS);
    localparam int CNT_W          = $clog2(MAX_PARTITIONS + 1);

    localparam int COORD_W = 32;
    localparam int POINT_W = 48;
    localparam int EXT_W   = POINT_W + 1;
    localparam int DIST_W  = 31;
    localparam int SQ_W    = 2 * DIST_W;
    localparam int D2_W    = SQ_W + 1;
    localparam int RECT_W  = 8 * COORD_W;

    localparam int IN_DATA_W  = 360;
    localparam int OUT_DATA_W = 24;

    localparam logic signed [EXT_W-1:0] DIST_CAP = EXT_W'(64'd1 << 30);

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    // data holds the rectangle edges of a write, or point y and x of a query
    typedef struct packed {
        logic              valid;
        op_t               op;
        logic [IDX_W-1:0]  idx;
        logic [RECT_W-1:0] data;
    } token_t;

    typedef struct packed {
        logic                      hit;
        logic [IDX_W-1:0]          primary;
        logic                      best_valid;
        logic [IDX_W-1:0]          best;
        logic [D2_W-1:0]           best_d2;
        logic [MAX_PARTITIONS-1:0] mask;
    } acc_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ppa_cell.sv -----
// ----------------------------------------------------------------------------
// ppa_cell: one partition cell of the assigner chain
// Holds one table entry, captures write words addressed to it and folds its
// core and halo tests into the passing query over three register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module ppa_cell
    import ppa_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             en,
    input  wire logic [IDX_W-1:0] cell_idx,
    input  wire logic [CNT_W-1:0] n_parts,
    input  wire token_t           tok_in,
    input  wire acc_t             acc_in,
    output token_t                tok_out,
    output acc_t                  acc_out
);

    function automatic logic signed [EXT_W-1:0] sx32(input logic [COORD_W-1:0] v);
        return $signed({{(EXT_W-COORD_W){v[COORD_W-1]}}, v});
    endfunction

    function automatic logic [DIST_W-1:0] axis_dist(
        input logic signed [EXT_W-1:0] p,
        input logic signed [EXT_W-1:0] lo,
        input logic signed [EXT_W-1:0] hi
    );
        logic signed [EXT_W-1:0] dl;
        logic signed [EXT_W-1:0] dh;
        logic signed [EXT_W-1:0] d;
        dl = lo - p;
        dh = p - hi;
        if (dl > 0) begin
            d = dl;
        end else if (dh > 0) begin
            d = dh;
        end else begin
            d = '0;
        end
        if (d >= DIST_CAP) begin
            d = DIST_CAP;
        end
        return d[DIST_W-1:0];
    endfunction

    // stored entry
    logic [RECT_W-1:0] entry_reg;

    logic signed [EXT_W-1:0] px, py;
    logic signed [EXT_W-1:0] cxl, cyl, cxh, cyh, hxl, hyl, hxh, hyh;

    token_t           s1_tok_reg, s2_tok_reg, tok_out_reg;
    acc_t             s1_acc_reg, s2_acc_reg, acc_out_reg, acc_out_next;
    logic [DIST_W-1:0] s1_dx_reg, s1_dy_reg, s1_dx_next, s1_dy_next;
    logic             s1_core_reg, s1_halo_reg, s1_core_next, s1_halo_next;
    logic [SQ_W-1:0]  s2_sqx_reg, s2_sqy_reg, s2_sqx_next, s2_sqy_next;
    logic             s2_core_reg, s2_halo_reg;
    logic [D2_W-1:0]  d2;
    logic             active;

    // stage 1: axis distances and containment
    always_comb begin
        px  = $signed({tok_in.data[POINT_W-1], tok_in.data[POINT_W-1:0]});
        py  = $signed({tok_in.data[2*POINT_W-1], tok_in.data[2*POINT_W-1:POINT_W]});
        cxl = sx32(entry_reg[0*COORD_W +: COORD_W]);
        cyl = sx32(entry_reg[1*COORD_W +: COORD_W]);
        cxh = sx32(entry_reg[2*COORD_W +: COORD_W]);
        cyh = sx32(entry_reg[3*COORD_W +: COORD_W]);
        hxl = sx32(entry_reg[4*COORD_W +: COORD_W]);
        hyl = sx32(entry_reg[5*COORD_W +: COORD_W]);
        hxh = sx32(entry_reg[6*COORD_W +: COORD_W]);
        hyh = sx32(entry_reg[7*COORD_W +: COORD_W]);
        s1_dx_next   = axis_dist(px, cxl, cxh);
        s1_dy_next   = axis_dist(py, cyl, cyh);
        s1_core_next = (px >= cxl) && (px < cxh) && (py >= cyl) && (py < cyh);
        s1_halo_next = (px >= hxl) && (px < hxh) && (py >= hyl) && (py < hyh);
    end

    always_ff @(posedge aclk) begin
        if (en && tok_in.valid && tok_in.op == OP_WRITE && tok_in.idx == cell_idx) begin
            entry_reg <= tok_in.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_tok_reg.valid <= 1'b0;
        end else if (en) begin
            s1_tok_reg <= tok_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_acc_reg  <= acc_in;
            s1_dx_reg   <= s1_dx_next;
            s1_dy_reg   <= s1_dy_next;
            s1_core_reg <= s1_core_next;
            s1_halo_reg <= s1_halo_next;
        end
    end

    // stage 2: squares
    assign s2_sqx_next = SQ_W'(s1_dx_reg) * SQ_W'(s1_dx_reg);
    assign s2_sqy_next = SQ_W'(s1_dy_reg) * SQ_W'(s1_dy_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_tok_reg.valid <= 1'b0;
        end else if (en) begin
            s2_tok_reg <= s1_tok_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_acc_reg  <= s1_acc_reg;
            s2_sqx_reg  <= s2_sqx_next;
            s2_sqy_reg  <= s2_sqy_next;
            s2_core_reg <= s1_core_reg;
            s2_halo_reg <= s1_halo_reg;
        end
    end

    // stage 3: fold into the running result
    assign active = {1'b0, cell_idx} < n_parts;
    assign d2     = D2_W'(s2_sqx_reg) + D2_W'(s2_sqy_reg);

    always_comb begin
        acc_out_next = s2_acc_reg;
        if (s2_tok_reg.valid && s2_tok_reg.op == OP_QUERY && active) begin
            if (!s2_acc_reg.hit && s2_core_reg) begin
                acc_out_next.hit     = 1'b1;
                acc_out_next.primary = cell_idx;
            end
            if (!s2_acc_reg.best_valid || d2 < s2_acc_reg.best_d2) begin
                acc_out_next.best_valid = 1'b1;
                acc_out_next.best       = cell_idx;
                acc_out_next.best_d2    = d2;
            end
            if (s2_halo_reg) begin
                acc_out_next.mask[cell_idx] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_out_reg.valid <= 1'b0;
        end else if (en) begin
            tok_out_reg <= s2_tok_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            acc_out_reg <= acc_out_next;
        end
    end

    assign tok_out = tok_out_reg;
    assign acc_out = acc_out_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/point_partition_assigner_unit.sv -----
// ----------------------------------------------------------------------------
// point_partition_assigner_unit: assigns query points to table partitions
// Write words load partition entries, query words return the primary
// partition, the halo copies mask and the nearest-core fallback flag.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel takes words; s_tuser selects write (0) or query (1).
//   A write word loads the entry named by entry_index and gives no result.
//   A query word gives exactly one result word on the m_ channel.
//   cfg_ channel sets partitions_in_use; write it only while the unit is
//   idle. Zero counts as one, values above 16 count as 16.
// Timing:
//   Every word walks a chain of 16 partition cells, three register stages
//   per cell (distance, square, compare), then one output register that
//   holds the query result. Throughput is one word per cycle while
//   m_tready stays high.
// Reset:
//   aresetn clears the chain valid bits and the output valid, and sets the
//   partition count to one; table entries are undefined until written.
// Stall:
//   when a result waits with m_tready low the whole chain holds and
//   s_tready drops; words in flight keep their place.
// ----------------------------------------------------------------------------
`default_nettype none

module point_partition_assigner_unit
    import ppa_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // configuration: partitions_in_use
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CNT_W-1:0]      cfg_data,
    // input words
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // entry_index[3:0], core_x_low[35:4], core_y_low[67:36], core_x_high[99:68],
    // core_y_high[131:100], halo_x_low[163:132], halo_y_low[195:164],
    // halo_x_high[227:196], halo_y_high[259:228], point_x[307:260],
    // point_y[355:308], zero fill[359:356]
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // op[0]
    input  wire logic                  s_tuser,
    // result words
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // primary_partition[3:0], copies_mask[19:4], zero fill[23:20]
    output logic [OUT_DATA_W-1:0]      m_tdata,
    // fallback_used[0]
    output logic                       m_tuser
);

    localparam int PT_LSB = IDX_W + RECT_W;

    logic             en;
    logic [CNT_W-1:0] n_reg, n_next;

    token_t tok_chain [0:MAX_PARTITIONS];
    acc_t   acc_chain [0:MAX_PARTITIONS];

    acc_t                      last_acc;
    logic [IDX_W-1:0]          primary_sel;
    logic [MAX_PARTITIONS-1:0] mask_sel;

    logic                      m_tvalid_reg;
    logic [IDX_W-1:0]          res_primary_reg;
    logic [MAX_PARTITIONS-1:0] res_mask_reg;
    logic                      res_fb_reg;

    // partition count
    assign cfg_ready = 1'b1;

    always_comb begin
        if (cfg_data == '0) begin
            n_next = CNT_W'(1);
        end else if (cfg_data > CNT_W'(MAX_PARTITIONS)) begin
            n_next = CNT_W'(MAX_PARTITIONS);
        end else begin
            n_next = cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg <= CNT_W'(1);
        end else if (cfg_valid) begin
            n_reg <= n_next;
        end
    end

    // chain entry
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    always_comb begin
        tok_chain[0].valid = s_tvalid;
        tok_chain[0].op    = op_t'(s_tuser);
        tok_chain[0].idx   = s_tdata[IDX_W-1:0];
        if (op_t'(s_tuser) == OP_WRITE) begin
            tok_chain[0].data = s_tdata[IDX_W +: RECT_W];
        end else begin
            tok_chain[0].data = {{(RECT_W-2*POINT_W){1'b0}}, s_tdata[PT_LSB +: 2*POINT_W]};
        end
        acc_chain[0] = '0;
    end

    for (genvar g = 0; g < MAX_PARTITIONS; g++) begin : g_cell
        ppa_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .cell_idx (IDX_W'(g)),
            .n_parts  (n_reg),
            .tok_in   (tok_chain[g]),
            .acc_in   (acc_chain[g]),
            .tok_out  (tok_chain[g+1]),
            .acc_out  (acc_chain[g+1])
        );
    end

    // result
    assign last_acc    = acc_chain[MAX_PARTITIONS];
    assign primary_sel = last_acc.hit ? last_acc.primary : last_acc.best;
    assign mask_sel    = last_acc.mask | (MAX_PARTITIONS'(1) << primary_sel);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= tok_chain[MAX_PARTITIONS].valid
                         && tok_chain[MAX_PARTITIONS].op == OP_QUERY;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_primary_reg <= primary_sel;
            res_mask_reg    <= mask_sel;
            res_fb_reg      <= !last_acc.hit;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_DATA_W-IDX_W-MAX_PARTITIONS){1'b0}}, res_mask_reg, res_primary_reg};
    assign m_tuser  = res_fb_reg;

`ifndef SYNTHESIS
    a_primary_in_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> res_mask_reg[res_primary_reg])
        else $error("primary partition missing from copies mask");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (n_reg != '0) && (n_reg <= CNT_W'(MAX_PARTITIONS)))
        else $error("partition count out of range");

    a_chain_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(tok_chain[MAX_PARTITIONS].valid))
        else $error("chain moved while output stalled");

    a_query_has_best: assert property (@(posedge aclk) disable iff (!aresetn)
        (tok_chain[MAX_PARTITIONS].valid && tok_chain[MAX_PARTITIONS].op == OP_QUERY)
        |-> last_acc.best_valid)
        else $error("query left the chain without a nearest core");
`endif

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking bench for point_partition_assigner_unit
// Loads partition tables over the input stream and sends query points.
// Expected placements come from a local predictor and are checked against
// every result word. Configuration is changed only while the unit is idle,
// and both stream sides idle or stall in random bursts.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import ppa_pkg::*;

    localparam int     CHAIN_LATENCY = 49;
    localparam int     DRAIN_LIMIT   = 20000;
    localparam longint DIST_LIMIT    = longint'(1) << 30;
    localparam int     EDGE_MIN      = 32'sh8000_0000;
    localparam int     EDGE_MAX      = 32'sh7fff_ffff;
    localparam longint POINT_MAX     = (longint'(1) << 47) - 1;
    localparam longint POINT_MIN     = -(longint'(1) << 47);

    typedef struct {
        logic signed [COORD_W-1:0] xl;
        logic signed [COORD_W-1:0] yl;
        logic signed [COORD_W-1:0] xh;
        logic signed [COORD_W-1:0] yh;
    } rect_t;

    typedef struct {
        op_t                       op;
        logic [IDX_W-1:0]          idx;
        rect_t                     core;
        rect_t                     halo;
        logic signed [POINT_W-1:0] px;
        logic signed [POINT_W-1:0] py;
    } in_word_t;

    typedef struct packed {
        logic                      fallback;
        logic [MAX_PARTITIONS-1:0] mask;
        logic [IDX_W-1:0]          primary;
    } place_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CNT_W-1:0]      cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;

    rect_t            core_tab [MAX_PARTITIONS];
    rect_t            halo_tab [MAX_PARTITIONS];
    logic [CNT_W-1:0] part_count = CNT_W'(1);
    place_t           expected_places [$];

    int gap_pct      = 0;
    int stall_pct    = 0;
    int fail_count   = 0;
    int writes_sent  = 0;
    int queries_sent = 0;
    int fallbacks    = 0;
    int results_seen = 0;

    point_partition_assigner_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #3_000_000;
        $display("tb: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // placement predictor
    // ------------------------------------------------------------------
    function automatic bit in_rect(input rect_t r, input longint x, input longint y);
        return longint'(r.xl) <= x && x < longint'(r.xh) &&
               longint'(r.yl) <= y && y < longint'(r.yh);
    endfunction

    function automatic longint axis_gap(input longint p, input longint lo, input longint hi);
        longint d;
        if (p < lo) begin
            d = lo - p;
        end else if (p > hi) begin
            d = p - hi;
        end else begin
            d = 0;
        end
        return (d < DIST_LIMIT) ? d : DIST_LIMIT;
    endfunction

    function automatic place_t place_point(input longint x, input longint y);
        place_t p;
        int     n;
        bit     hit;
        int     best;
        longint best_d2;
        longint dx;
        longint dy;
        longint d2;
        n = (part_count == 0) ? 1 :
            (part_count > MAX_PARTITIONS) ? MAX_PARTITIONS : int'(part_count);
        hit     = 1'b0;
        best    = 0;
        best_d2 = 64'sh7fff_ffff_ffff_ffff;
        p       = '0;
        for (int i = 0; i < n; i++) begin
            if (!hit && in_rect(core_tab[i], x, y)) begin
                hit       = 1'b1;
                p.primary = IDX_W'(i);
            end
            dx = axis_gap(x, core_tab[i].xl, core_tab[i].xh);
            dy = axis_gap(y, core_tab[i].yl, core_tab[i].yh);
            d2 = dx * dx + dy * dy;
            if (d2 < best_d2) begin
                best_d2 = d2;
                best    = i;
            end
            if (in_rect(halo_tab[i], x, y))
                p.mask[i] = 1'b1;
        end
        if (!hit)
            p.primary = IDX_W'(best);
        p.mask[p.primary] = 1'b1;
        p.fallback        = !hit;
        return p;
    endfunction

    function automatic void track_word(input in_word_t w);
        place_t p;
        if (w.op == OP_WRITE) begin
            core_tab[w.idx] = w.core;
            halo_tab[w.idx] = w.halo;
            writes_sent++;
        end else begin
            p = place_point(w.px, w.py);
            expected_places = {expected_places, p};
            queries_sent++;
            if (p.fallback)
                fallbacks++;
        end
    endfunction

    // ------------------------------------------------------------------
    // result check
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        place_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (expected_places.size() == 0) begin
                $error("unexpected result word: primary %0d mask %h fallback %0b",
                       m_tdata[IDX_W-1:0], m_tdata[IDX_W +: MAX_PARTITIONS], m_tuser);
                fail_count++;
            end else begin
                want = expected_places.pop_front();
                if (m_tdata[IDX_W-1:0] !== want.primary) begin
                    $error("primary_partition: expected %0d, got %0d",
                           want.primary, m_tdata[IDX_W-1:0]);
                    fail_count++;
                end
                if (m_tdata[IDX_W +: MAX_PARTITIONS] !== want.mask) begin
                    $error("copies_mask: expected %h, got %h",
                           want.mask, m_tdata[IDX_W +: MAX_PARTITIONS]);
                    fail_count++;
                end
                if (m_tuser !== want.fallback) begin
                    $error("fallback_used: expected %0b, got %0b", want.fallback, m_tuser);
                    fail_count++;
                end
            end
        end
    end

    // result side back-pressure
    initial begin
        m_tready <= 1'b1;
        forever begin
            @(posedge aclk);
            if ($urandom_range(0, 99) < stall_pct) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // word builders
    // ------------------------------------------------------------------
    function automatic logic [POINT_W-1:0] rand48();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[POINT_W-1:0];
    endfunction

    function automatic int near(input int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic rect_t mk_rect(input int xl, input int yl, input int xh, input int yh);
        rect_t r;
        r.xl = xl;
        r.yl = yl;
        r.xh = xh;
        r.yh = yh;
        return r;
    endfunction

    function automatic rect_t rand_rect();
        return mk_rect($urandom, $urandom, $urandom, $urandom);
    endfunction

    function automatic rect_t scatter_rect();
        rect_t r;
        int    k;
        k = $urandom_range(0, 9);
        if (k < 7) begin
            r.xl = near(90);
            r.yl = near(90);
            r.xh = r.xl + int'($urandom_range(1, 50));
            r.yh = r.yl + int'($urandom_range(1, 50));
        end else if (k < 9) begin
            r = rand_rect();
        end else begin
            // empty or inverted
            r.xl = near(90);
            r.yl = near(90);
            r.xh = r.xl - int'($urandom_range(0, 20));
            r.yh = r.yl + int'($urandom_range(0, 20)) - 10;
        end
        return r;
    endfunction

    function automatic rect_t grow_rect(input rect_t c);
        rect_t h;
        if ($urandom_range(0, 7) == 0)
            return rand_rect();
        h.xl = c.xl - int'($urandom_range(0, 12));
        h.yl = c.yl - int'($urandom_range(0, 12));
        h.xh = c.xh + int'($urandom_range(0, 12));
        h.yh = c.yh + int'($urandom_range(0, 12));
        return h;
    endfunction

    function automatic in_word_t noise_word(input op_t op);
        in_word_t w;
        w.op   = op;
        w.idx  = IDX_W'($urandom_range(0, MAX_PARTITIONS - 1));
        w.core = rand_rect();
        w.halo = rand_rect();
        w.px   = rand48();
        w.py   = rand48();
        return w;
    endfunction

    function automatic void pick_point(output longint x, output longint y);
        int    k;
        rect_t r;
        k = $urandom_range(0, 19);
        r = $urandom_range(0, 1) ? core_tab[$urandom_range(0, MAX_PARTITIONS - 1)]
                                 : halo_tab[$urandom_range(0, MAX_PARTITIONS - 1)];
        if (k < 12) begin
            x = near(110);
            y = near(110);
        end else if (k < 16) begin
            // on or next to an edge
            case ($urandom_range(0, 3))
                0: x = r.xl;
                1: x = longint'(r.xl) - 1;
                2: x = r.xh;
                default: x = longint'(r.xh) - 1;
            endcase
            case ($urandom_range(0, 3))
                0: y = r.yl;
                1: y = longint'(r.yl) - 1;
                2: y = r.yh;
                default: y = longint'(r.yh) - 1;
            endcase
        end else if (k < 18) begin
            // around the distance cap
            x = near(110) + ($urandom_range(0, 1) ? 1 : -1) *
                (longint'(1) << $urandom_range(29, 46));
            y = near(110);
        end else begin
            x = longint'($signed(rand48()));
            y = longint'($signed(rand48()));
        end
    endfunction

    // ------------------------------------------------------------------
    // channel drivers
    // ------------------------------------------------------------------
    task automatic send_word(input in_word_t w);
        s_tdata  <= {4'b0, w.py, w.px, w.halo.yh, w.halo.xh, w.halo.yl, w.halo.xl,
                     w.core.yh, w.core.xh, w.core.yl, w.core.xl, w.idx};
        s_tuser  <= w.op;
        s_tvalid <= 1'b1;
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
        track_word(w);
        if ($urandom_range(0, 99) < gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
    endtask

    task automatic send_entry(input logic [IDX_W-1:0] idx, input rect_t core,
                              input rect_t halo);
        in_word_t w;
        w      = noise_word(OP_WRITE);
        w.idx  = idx;
        w.core = core;
        w.halo = halo;
        send_word(w);
    endtask

    task automatic send_query(input longint x, input longint y);
        in_word_t w;
        w    = noise_word(OP_QUERY);
        w.px = x[POINT_W-1:0];
        w.py = y[POINT_W-1:0];
        send_word(w);
    endtask

    // stop sending, let every result come out and the chain empty
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        for (int i = 0; i < DRAIN_LIMIT && expected_places.size() != 0; i++)
            @(posedge aclk);
        repeat (CHAIN_LATENCY + 8) @(posedge aclk);
    endtask

    task automatic set_count(input logic [CNT_W-1:0] v);
        wait_idle();
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do @(negedge aclk); while (!cfg_ready);
        @(posedge aclk);
        cfg_valid  <= 1'b0;
        part_count = v;
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_reset_count();
        send_entry(IDX_W'(0), mk_rect(10, 0, 20, 10), mk_rect(0, -10, 30, 20));
        send_entry(IDX_W'(1), mk_rect(-20, 0, -10, 10), mk_rect(-30, -10, 0, 20));
        send_entry(IDX_W'(2), mk_rect(10, 0, 20, 10), mk_rect(30, -10, 0, 20));
        send_entry(IDX_W'(3), mk_rect(50, 0, 40, 10), mk_rect(50, 0, 40, 10));
        send_entry(IDX_W'(4), mk_rect(EDGE_MIN, EDGE_MIN, EDGE_MAX, EDGE_MAX),
                   mk_rect(EDGE_MIN, EDGE_MIN, EDGE_MAX, EDGE_MAX));
        for (int i = 5; i < MAX_PARTITIONS; i++)
            send_entry(IDX_W'(i), mk_rect(100 * i, 0, 100 * i + 5, 5),
                       mk_rect(100 * i - 3, -3, 100 * i + 8, 8));
        send_query(15, 5);
        send_query(0, 5);
    endtask

    task automatic test_core_and_fallback();
        set_count(CNT_W'(4));
        send_query(0, 5);
        send_query(15, 5);
        send_query(-15, 5);
        send_query(45, 5);
        send_query(10, 0);
        send_query(20, 5);
    endtask

    task automatic test_count_limits();
        set_count(CNT_W'(0));
        send_query(-15, 5);
        set_count(CNT_W'(31));
        send_query(1000, 1000);
        set_count(CNT_W'(17));
        send_query(1500, 2);
        set_count(CNT_W'(16));
        send_query(EDGE_MAX, 0);
    endtask

    task automatic test_extremes();
        send_query(POINT_MAX, POINT_MAX);
        send_query(POINT_MIN, POINT_MIN);
        send_query(longint'(1) << 40, 5);
        send_query(EDGE_MIN, EDGE_MIN);
    endtask

    task automatic run_phase(input logic [CNT_W-1:0] count, input int words,
                             input int gaps, input int stalls, input bit pause);
        longint x;
        longint y;
        rect_t  c;
        int     grid_w;
        bit     grid;
        set_count(count);
        gap_pct   = gaps;
        stall_pct = stalls;
        grid      = $urandom_range(0, 1);
        grid_w    = $urandom_range(8, 40);
        for (int i = 0; i < MAX_PARTITIONS; i++) begin
            if (grid) begin
                c.xl = -2 * grid_w + (i % 4) * grid_w;
                c.yl = -2 * grid_w + (i / 4) * grid_w;
                c.xh = c.xl + grid_w;
                c.yh = c.yl + grid_w;
            end else begin
                c = scatter_rect();
            end
            send_entry(IDX_W'(i), c, grow_rect(c));
        end
        for (int i = 0; i < words; i++) begin
            if (pause && i == words / 2)
                wait_idle();
            if ($urandom_range(0, 4) == 0) begin
                c = scatter_rect();
                send_entry(IDX_W'($urandom_range(0, MAX_PARTITIONS - 1)), c, grow_rect(c));
            end else begin
                pick_point(x, y);
                send_query(x, y);
            end
        end
    endtask

    task automatic test_random_traffic();
        run_phase(CNT_W'(0), 120, 20, 10, 1'b0);
        run_phase(CNT_W'(16), 120, 0, 0, 1'b1);
        run_phase(CNT_W'(31), 120, 30, 25, 1'b0);
        run_phase(CNT_W'($urandom_range(2, 15)), 120, 10, 40, 1'b0);
        run_phase(CNT_W'($urandom_range(17, 30)), 120, 40, 5, 1'b1);
        run_phase(CNT_W'($urandom_range(0, 31)), 120, 0, 0, 1'b0);
    endtask

    initial begin
        aresetn   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        gap_pct   = 25;
        stall_pct = 15;
        test_reset_count();
        test_core_and_fallback();
        test_count_limits();
        test_extremes();
        test_random_traffic();

        wait_idle();
        if (expected_places.size() != 0) begin
            $error("%0d expected results never arrived", expected_places.size());
            fail_count++;
        end
        $display("tb: %0d table writes and %0d point queries sent, %0d results checked",
                 writes_sent, queries_sent, results_seen);
        $display("tb: %0d queries fell back to the nearest core, counts 0..31 exercised",
                 fallbacks);
        if (fail_count == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
